// ===== rtl/core/sist_pkg.sv =====
// Shared constants, types and command struct for the sorted index set toggle unit.
package sist_pkg;

  localparam int MAX_COLS = 64;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;
  localparam logic [CNT_W-1:0] MIN_HELD = CNT_W'(2);
  localparam logic [CNT_W-1:0] COLS_MAX = CNT_W'(MAX_COLS);

  typedef enum logic [2:0] {
    ACT_ADDED   = 3'd0,
    ACT_REMOVED = 3'd1,
    ACT_REFUSED = 3'd2,
    ACT_RANGE   = 3'd3,
    ACT_FILLED  = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_FILL   = 2'd3
  } cmd_op_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cmd_op_t          op;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] ncols;
  } cell_cmd_t;

endpackage

// ===== rtl/core/sist_cell.sv =====
// One list slot: holds an index and its valid bit, shifts with its neighbors.
module sist_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [sist_pkg::IDX_W-1:0] slot,
  input  sist_pkg::cell_cmd_t       cmd,
  input  logic [sist_pkg::IDX_W-1:0] left_value,
  input  logic                      left_valid,
  input  logic                      left_lt,
  input  logic [sist_pkg::IDX_W-1:0] right_value,
  input  logic                      right_valid,
  output logic [sist_pkg::IDX_W-1:0] value,
  output logic                      valid,
  output logic                      lt,
  output logic                      match
);
  import sist_pkg::*;

  logic [IDX_W-1:0] value_next;
  logic             valid_next;

  // Held entry below the requested index / equal to it.
  assign lt    = valid && (value < cmd.idx);
  assign match = valid && (value == cmd.idx);

  always_comb begin
    value_next = value;
    valid_next = valid;
    case (cmd.op)
      CMD_FILL: begin
        value_next = slot;
        valid_next = ({1'b0, slot} < cmd.ncols);
      end
      CMD_REMOVE: begin
        if (!lt) begin
          value_next = right_value;
          valid_next = right_valid;
        end
      end
      CMD_INSERT: begin
        if (!lt) begin
          value_next = left_lt ? cmd.idx : left_value;
          valid_next = valid | left_valid;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= slot;
      valid <= 1'b1;
    end else begin
      value <= value_next;
      valid <= valid_next;
    end
  end

endmodule

// ===== rtl/core/sist_therm_enc.sv =====
// Thermometer-code to count encoder for the less-than flags of the chain.
module sist_therm_enc (
  input  logic [sist_pkg::MAX_COLS-1:0] therm,
  output logic [sist_pkg::CNT_W-1:0]    ones
);
  import sist_pkg::*;

  logic [MAX_COLS-1:0] edge_hot;

  // Flags form a prefix of ones; the last one marks the count.
  always_comb begin
    for (int j = 0; j < MAX_COLS - 1; j++) begin
      edge_hot[j] = therm[j] & ~therm[j+1];
    end
    edge_hot[MAX_COLS-1] = therm[MAX_COLS-1];
  end

  always_comb begin
    ones = '0;
    for (int j = 0; j < MAX_COLS; j++) begin
      ones = ones | (edge_hot[j] ? CNT_W'(j + 1) : '0);
    end
  end

endmodule

// ===== rtl/core/sorted_index_set_toggle_unit.sv =====
// Top level: sorted set of selected column indices with toggle and fill.
//
//  channel  dir  fields (low bit first)
//  -------  ---  ------------------------------------------------------
//  s_*      in   tuser[0] func; tdata[5:0] var_index
//  m_*      out  tuser[2:0] action; tdata[5:0] position, [12:6] selected_count
//  cfg_*    in   cfg_wdata[6:0] cols_in_use, written when cfg_wen is high
//
// Cycles: one word per cycle unless the output is held; every cell of the
// 64-slot chain compares its entry with the index, and on a toggle those at
// or above it shift. m_* shows the result in the cycle after acceptance.
// Reset: list holds 0..63, count 64, cols_in_use 64.
// Stalls: a single output register; s_tready is high while it is empty or
// being drained, so input stalls only when the output is held.
module sorted_index_set_toggle_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [5:0] var_index
  input  logic [0:0]  s_tuser,   // [0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [5:0] position, [12:6] selected_count
  output logic [2:0]  m_tuser,   // [2:0] action
  input  logic        cfg_wen,
  input  logic [6:0]  cfg_wdata  // [6:0] cols_in_use
);
  import sist_pkg::*;

  // Configuration and count.
  logic [CNT_W-1:0] cols_in_use;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] ncols;

  // Chain signals.
  logic [IDX_W-1:0]    cell_value [MAX_COLS];
  logic [MAX_COLS-1:0] cell_valid;
  logic [MAX_COLS-1:0] cell_lt;
  logic [MAX_COLS-1:0] cell_match;
  cell_cmd_t           cmd;

  // Decode.
  logic             accept;
  logic             func;
  logic [IDX_W-1:0] idx;
  logic             in_range;
  logic             found;
  logic             full;
  logic [CNT_W-1:0] lt_count;
  action_t          action;
  logic [IDX_W-1:0] position;

  // Output register.
  action_t          out_action;
  logic [IDX_W-1:0] out_position;
  logic [CNT_W-1:0] out_count;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign func     = s_tuser[0];
  assign idx      = s_tdata[IDX_W-1:0];

  // Effective column count, clamped to 2..MAX_COLS.
  always_comb begin
    if (cols_in_use < MIN_HELD) begin
      ncols = MIN_HELD;
    end else if (cols_in_use > COLS_MAX) begin
      ncols = COLS_MAX;
    end else begin
      ncols = cols_in_use;
    end
  end

  assign in_range = ({1'b0, idx} < ncols);
  assign found    = |cell_match;
  assign full     = (count == COLS_MAX);

  // Sorted list: slot of a held index, or insertion slot, is the number
  // of held entries below it.
  sist_therm_enc u_enc (
    .therm (cell_lt),
    .ones  (lt_count)
  );

  always_comb begin
    action     = ACT_ADDED;
    position   = '0;
    count_next = count;
    cmd.op     = CMD_HOLD;
    cmd.idx    = idx;
    cmd.ncols  = ncols;
    if (func) begin
      action     = ACT_FILLED;
      count_next = ncols;
      cmd.op     = CMD_FILL;
    end else if (!in_range) begin
      action = ACT_RANGE;
    end else if (found) begin
      if (count > MIN_HELD) begin
        action     = ACT_REMOVED;
        position   = lt_count[IDX_W-1:0];
        count_next = count - CNT_W'(1);
        cmd.op     = CMD_REMOVE;
      end else begin
        action = ACT_REFUSED;
      end
    end else if (full) begin
      action = ACT_RANGE;  // absent but no free slot
    end else begin
      action     = ACT_ADDED;
      position   = lt_count[IDX_W-1:0];
      count_next = count + CNT_W'(1);
      cmd.op     = CMD_INSERT;
    end
    if (!accept) begin
      cmd.op = CMD_HOLD;
    end
  end

  // Row of cells; slot 0 sees a boundary on its left, the last slot an
  // empty entry on its right.
  for (genvar j = 0; j < MAX_COLS; j++) begin : g_cell
    logic [IDX_W-1:0] left_value;
    logic             left_valid;
    logic             left_lt;
    logic [IDX_W-1:0] right_value;
    logic             right_valid;

    if (j == 0) begin : g_first
      assign left_value = cell_value[j];
      assign left_valid = 1'b1;
      assign left_lt    = 1'b1;
    end else begin : g_mid_l
      assign left_value = cell_value[j-1];
      assign left_valid = cell_valid[j-1];
      assign left_lt    = cell_lt[j-1];
    end

    if (j == MAX_COLS - 1) begin : g_last
      assign right_value = cell_value[j];
      assign right_valid = 1'b0;
    end else begin : g_mid_r
      assign right_value = cell_value[j+1];
      assign right_valid = cell_valid[j+1];
    end

    sist_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .slot        (IDX_W'(j)),
      .cmd         (cmd),
      .left_value  (left_value),
      .left_valid  (left_valid),
      .left_lt     (left_lt),
      .right_value (right_value),
      .right_valid (right_valid),
      .value       (cell_value[j]),
      .valid       (cell_valid[j]),
      .lt          (cell_lt[j]),
      .match       (cell_match[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= COLS_MAX;
      count       <= COLS_MAX;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_wen) begin
        cols_in_use <= cfg_wdata;
      end
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_action   <= action;
      out_position <= position;
      out_count    <= count_next;
    end
  end

  assign m_tuser = out_action;
  assign m_tdata = {3'b000, out_count, out_position};

endmodule
